>>> sv/ppis_pkg.sv
`timescale 1ns / 1ps
// Package for the positional PID with integral separation.
// Holds the shared widths, constants, register codes and the sequencer state type.
package ppis_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned WEIGHT_W = FRAC_W + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

  // The band quotient is at most one, so it has one integer bit and FRAC_W fraction bits.
  localparam int unsigned DIV_STEPS = WEIGHT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_OUT_LIMIT  = 3'd3,
    CFG_INT_LIMIT  = 3'd4,
    CFG_BEGIN_BAND = 3'd5,
    CFG_FULL_BAND  = 3'd6,
    CFG_SEP_EN     = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_BAND,
    S_DIV,
    S_INTEG,
    S_MUL_P,
    S_MUL_D,
    S_MUL_I1,
    S_MUL_I2,
    S_SUM,
    S_CLAMP,
    S_DONE
  } state_e;

endpackage

>>> sv/ppis_in_if.sv
`timescale 1ns / 1ps
// Input channel of the PID block: valid/ready handshake plus one input word.
// Depends on ppis_pkg for the field width.
interface ppis_in_if;
  import ppis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] ff_threshold;
  logic signed [DATA_W-1:0] ff_step;

  modport source (output valid, setpoint, measured, ff_threshold, ff_step, input ready);
  modport sink   (input valid, setpoint, measured, ff_threshold, ff_step, output ready);
endinterface

>>> sv/ppis_out_if.sv
`timescale 1ns / 1ps
// Output channel of the PID block: valid/ready handshake plus one result word.
// Depends on ppis_pkg for the field width.
interface ppis_out_if;
  import ppis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] error_value;

  modport source (output valid, drive, error_value, input ready);
  modport sink   (input valid, drive, error_value, output ready);
endinterface

>>> sv/ppis_div.sv
`timescale 1ns / 1ps
// Restoring divider that forms the middle-band integral weight, one quotient bit a cycle.
// Depends on ppis_pkg for widths and the step count.
module ppis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppis_pkg::DATA_W-1:0]   num_i,
  input  logic [ppis_pkg::LIMIT_W-1:0]  den_i,
  output logic                          done_o,
  output logic [ppis_pkg::WEIGHT_W-1:0] quot_o
);
  import ppis_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [LIMIT_W-1:0]   den_q, den_d;
  logic [WEIGHT_W-1:0]  quot_q, quot_d;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 qbit;

  // The numerator is scaled by 2^16; the first step compares it unshifted, which
  // yields the integer bit of the quotient, and the rest shift one bit each.
  always_comb begin
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {{(DATA_W + 1 - LIMIT_W){1'b0}}, den_q};
    qbit  = (trial >= {{(DATA_W + 1 - LIMIT_W){1'b0}}, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quot_d = {quot_q[WEIGHT_W-2:0], qbit};
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/position_pid_integral_separation.sv
`timescale 1ns / 1ps
// Positional PID controller with integral separation and feed-forward, signed Q16.16.
// Depends on ppis_pkg, ppis_in_if, ppis_out_if and ppis_div.
//
// Usage: one input word (setpoint, measured, feed-forward threshold and step) on in_i
// gives exactly one result word (drive and the saturated error) on out_o. Both channels
// move a word at a rising edge where valid and ready are high. Gains, limits, bands and
// the separation enable are written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle.
// From acceptance a word passes through the error, band, integral, multiply, sum, clamp
// and done states before its result is offered; when the error lies in the middle band
// the weight divider runs in between (17 quotient steps, then its done flag).
// The block takes one word at a time: in_i.ready is high only while the sequencer waits
// for input, so a new word is taken only once the last result has reached the output
// register. The pace is set by the sequencer that steps one shared multiplier through the
// four products in turn and by the bit-serial weight divider.
// A finished result sits in the output register; a new word is accepted meanwhile, and
// the sequencer holds in its last state until that register has been emptied.
// Reset clears the integral and the previous error and loads the register defaults:
// zero gains, full-scale limits, zero bands and separation disabled.
module position_pid_integral_separation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppis_pkg::CFG_W-1:0]     cfg_data_i,
  ppis_in_if.sink                        in_i,
  ppis_out_if.source                     out_o
);
  import ppis_pkg::*;

  localparam int unsigned DIFF_W = DATA_W + 1;   // exact setpoint minus measured
  localparam int unsigned MA_W   = 42;           // multiplier operand A, holds the first I product
  localparam int unsigned MB_W   = GAIN_W + 1;   // multiplier operand B, unsigned made signed
  localparam int unsigned MP_W   = MA_W + MB_W;
  localparam int unsigned PROD_W = 58;           // every product fits here
  localparam int unsigned TERM_W = PROD_W - FRAC_W;
  localparam int unsigned SUM_W  = TERM_W + 2;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] max_v;
    logic signed [DATA_W+1:0] min_v;
    max_v = (DATA_W + 2)'(2**(DATA_W - 1) - 1);
    min_v = -max_v - (DATA_W + 2)'(1);
    if (v > max_v) begin
      sat32 = {1'b0, {(DATA_W - 1){1'b1}}};
    end else if (v < min_v) begin
      sat32 = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0] out_lim_q, int_lim_q, begin_q, full_q;
  logic               sep_q;

  // Controller state.
  logic signed [DATA_W-1:0] integ_sum_q, integ_sum_d;
  logic signed [DATA_W-1:0] prev_err_q;

  // Per-word working registers.
  state_e                   state_q, state_d;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [DATA_W-1:0] thr_q, step_q;
  logic signed [DATA_W-1:0] err_q;
  logic [DATA_W-1:0]        mag_q;
  logic signed [DIFF_W-1:0] delta_q;
  logic                     integ_en_q;
  logic [WEIGHT_W-1:0]      weight_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] clamped_q;
  logic                     ff_add_q, ff_sub_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q, err_out_q;

  // Control produced by the sequencer.
  logic                    in_ready;
  logic                    div_start;
  logic                    out_load;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;

  // Datapath helpers.
  logic signed [DATA_W-1:0] err_sat;
  logic [DATA_W-1:0]        err_mag;
  logic                     above_begin, below_full, den_pos, div_needed;
  logic signed [MP_W-1:0]   mul_full;
  logic signed [TERM_W-1:0] term;
  logic signed [DATA_W:0]   integ_raw;
  logic signed [DATA_W-1:0] integ_sat;
  logic signed [DATA_W:0]   int_lim_s;
  logic signed [SUM_W-1:0]  out_lim_s;
  logic signed [DATA_W-1:0] sum_clamped;
  logic signed [DATA_W+1:0] diff_neg;
  logic signed [DATA_W+1:0] ff_result;
  logic                     div_done;
  logic [WEIGHT_W-1:0]      div_quot;
  logic [DATA_W-1:0]        div_num;

  // ---------------------------------------------------------------------------
  // Configuration writes. Every index of the three-bit field names a register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      out_lim_q <= '1;
      int_lim_q <= '1;
      begin_q   <= '0;
      full_q    <= '0;
      sep_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:     gain_p_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_OUT_LIMIT:  out_lim_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_INT_LIMIT:  int_lim_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_BEGIN_BAND: begin_q   <= cfg_data_i[LIMIT_W-1:0];
        CFG_FULL_BAND:  full_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_SEP_EN:     sep_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Error, band decision and integral update.
  // ---------------------------------------------------------------------------
  always_comb begin
    err_sat = sat32({diff_q[DIFF_W-1], diff_q});
    err_mag = err_sat[DATA_W-1] ? (~err_sat + DATA_W'(1)) : err_sat;
  end

  // The begin test takes priority over the full-band test, so inverted bands still
  // give a defined weight. A non-positive band width means weight one.
  always_comb begin
    above_begin = sep_q && (mag_q > {1'b0, begin_q});
    below_full  = mag_q < {1'b0, full_q};
    den_pos     = begin_q > full_q;
    div_needed  = sep_q && !above_begin && !below_full && den_pos;
    div_num     = {1'b0, begin_q} - mag_q;
  end

  // Integral: add the error with saturation unless separated, then clamp.
  always_comb begin
    integ_raw = {integ_sum_q[DATA_W-1], integ_sum_q} + {err_q[DATA_W-1], err_q};
    integ_sat = integ_en_q ? sat32({integ_raw[DATA_W], integ_raw})
                           : integ_sum_q;
    int_lim_s = $signed({2'b00, int_lim_q});
    if ($signed({integ_sat[DATA_W-1], integ_sat}) > int_lim_s) begin
      integ_sum_d = int_lim_s[DATA_W-1:0];
    end else if ($signed({integ_sat[DATA_W-1], integ_sat}) < -int_lim_s) begin
      integ_sum_d = DATA_W'(-int_lim_s);
    end else begin
      integ_sum_d = integ_sat;
    end
  end

  ppis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (begin_q - full_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier. Every product is floored by 16 bits, which is an
  // arithmetic shift of the registered product.
  // ---------------------------------------------------------------------------
  assign mul_full = mul_a * mul_b;
  assign term     = prod_q[PROD_W-1:FRAC_W];

  // Symmetric clamp of P+I+D.
  always_comb begin
    out_lim_s = $signed({{(SUM_W - LIMIT_W){1'b0}}, out_lim_q});
    if (sum_q > out_lim_s) begin
      sum_clamped = out_lim_s[DATA_W-1:0];
    end else if (sum_q < -out_lim_s) begin
      sum_clamped = DATA_W'(-out_lim_s);
    end else begin
      sum_clamped = sum_q[DATA_W-1:0];
    end
  end

  // Feed-forward uses the exact difference, not the saturated error.
  always_comb begin
    diff_neg  = -$signed({diff_q[DIFF_W-1], diff_q});
    ff_result = {{2{clamped_q[DATA_W-1]}}, clamped_q};
    if (ff_add_q) begin
      ff_result = ff_result + {{2{step_q[DATA_W-1]}}, step_q};
    end else if (ff_sub_q) begin
      ff_result = ff_result - {{2{step_q[DATA_W-1]}}, step_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_ERR;
      S_ERR:    state_d = S_BAND;
      S_BAND:   state_d = div_needed ? S_DIV : S_INTEG;
      S_DIV:    if (div_done) state_d = S_INTEG;
      S_INTEG:  state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_D;
      S_MUL_D:  state_d = S_MUL_I1;
      S_MUL_I1: state_d = S_MUL_I2;
      S_MUL_I2: state_d = S_SUM;
      S_SUM:    state_d = S_CLAMP;
      S_CLAMP:  state_d = S_DONE;
      S_DONE:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer: control outputs and multiplier operand selection.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      S_IDLE:   in_ready  = 1'b1;
      S_BAND:   div_start = div_needed;
      S_MUL_P: begin
        mul_a = MA_W'(err_q);
        mul_b = $signed({1'b0, gain_p_q});
      end
      S_MUL_D: begin
        mul_a = MA_W'(delta_q);
        mul_b = $signed({1'b0, gain_d_q});
      end
      S_MUL_I1: begin
        mul_a = MA_W'(integ_sum_q);
        mul_b = $signed({1'b0, gain_i_q});
      end
      S_MUL_I2: begin
        mul_a = term;
        mul_b = $signed({{(MB_W - WEIGHT_W){1'b0}}, weight_q});
      end
      S_DONE:   out_load  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      integ_sum_q <= '0;
      prev_err_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_INTEG) begin
        integ_sum_q <= integ_sum_d;
      end
      if (state_q == S_BAND) begin
        prev_err_q <= err_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          diff_q <= {in_i.setpoint[DATA_W-1], in_i.setpoint}
                  - {in_i.measured[DATA_W-1], in_i.measured};
          thr_q  <= in_i.ff_threshold;
          step_q <= in_i.ff_step;
        end
      end
      S_ERR: begin
        err_q <= err_sat;
        mag_q <= err_mag;
      end
      S_BAND: begin
        delta_q    <= {err_q[DATA_W-1], err_q} - {prev_err_q[DATA_W-1], prev_err_q};
        integ_en_q <= !above_begin;
        weight_q   <= above_begin ? '0 : WEIGHT_ONE;
      end
      S_DIV: begin
        if (div_done) begin
          weight_q <= div_quot;
        end
      end
      S_MUL_P: begin
        prod_q <= mul_full[PROD_W-1:0];
        sum_q  <= '0;
      end
      S_MUL_D, S_MUL_I1: begin
        prod_q <= mul_full[PROD_W-1:0];
        sum_q  <= sum_q + SUM_W'(term);
      end
      S_MUL_I2: begin
        prod_q <= mul_full[PROD_W-1:0];
      end
      S_SUM: begin
        sum_q <= sum_q + SUM_W'(term);
      end
      S_CLAMP: begin
        clamped_q <= sum_clamped;
        ff_add_q  <= $signed({diff_q[DIFF_W-1], diff_q})
                   > $signed({{2{thr_q[DATA_W-1]}}, thr_q});
        ff_sub_q  <= diff_neg > $signed({{2{thr_q[DATA_W-1]}}, thr_q});
      end
      S_DONE: begin
        if (out_load) begin
          drive_q   <= sat32(ff_result);
          err_out_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.drive       = drive_q;
  assign out_o.error_value = err_out_q;

endmodule

>>> dv/ppis_drive_checker.sv
`timescale 1ns / 1ps
// Result checker for the positional PID block: tracks register writes, predicts each result
// word from the accepted input words and compares it with what the block delivers.
// Depends on ppis_pkg, ppis_in_if and ppis_out_if.
module ppis_drive_checker
  import ppis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  ppis_in_if                   in_mon,
  ppis_out_if                  out_mon,
  output int                   mismatch_cnt_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_value;
  } pid_result_t;

  pid_result_t expected_drive_q[$];

  logic [GAIN_W-1:0]        kp, ki, kd;
  logic [LIMIT_W-1:0]       out_lim, int_lim, band_hi, band_lo;
  logic                     sep_en;
  logic signed [DATA_W-1:0] integ_sum, last_err;
  int                       mismatch_cnt, checked_cnt;

  function automatic longint sat_word(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
    if (v < longint'(32'sh80000000)) return longint'(32'sh80000000);
    return v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One control step: updates the integral and the last error, returns the result word.
  task automatic advance_loop(input logic signed [DATA_W-1:0] sp_w, ms_w, thr_w, stp_w,
                              output pid_result_t res);
    longint diff, err, mag, den, wgt, acc, p_term, i_term, d_term, total;
    bit     integ;
    diff  = longint'(sp_w) - longint'(ms_w);
    err   = sat_word(diff);
    mag   = (err < 0) ? -err : err;
    wgt   = longint'(WEIGHT_ONE);
    integ = 1'b1;
    if (sep_en) begin
      if (mag > longint'(band_hi)) begin
        integ = 1'b0;
        wgt   = 0;
      end else if (mag < longint'(band_lo)) begin
        wgt = longint'(WEIGHT_ONE);
      end else begin
        den = longint'(band_hi) - longint'(band_lo);
        if (den > 0) wgt = ((longint'(band_hi) - mag) <<< FRAC_W) / den;
        else wgt = longint'(WEIGHT_ONE);
      end
    end
    acc = longint'(integ_sum);
    if (integ) acc = sat_word(acc + err);
    acc       = clamp_sym(acc, longint'(int_lim));
    integ_sum = acc[DATA_W-1:0];
    // Arithmetic shifts of signed values round toward minus infinity.
    p_term = (longint'(kp) * err) >>> FRAC_W;
    i_term = (longint'(ki) * acc) >>> FRAC_W;
    i_term = (i_term * wgt) >>> FRAC_W;
    d_term = (longint'(kd) * (err - longint'(last_err))) >>> FRAC_W;
    total  = clamp_sym(p_term + i_term + d_term, longint'(out_lim));
    if (diff > longint'(thr_w)) total = total + longint'(stp_w);
    else if (-diff > longint'(thr_w)) total = total - longint'(stp_w);
    total           = sat_word(total);
    last_err        = err[DATA_W-1:0];
    res.drive       = total[DATA_W-1:0];
    res.error_value = err[DATA_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    pid_result_t want, got;
    if (!rst_ni) begin
      kp           = '0;
      ki           = '0;
      kd           = '0;
      out_lim      = '1;
      int_lim      = '1;
      band_hi      = '0;
      band_lo      = '0;
      sep_en       = 1'b0;
      integ_sum    = '0;
      last_err     = '0;
      mismatch_cnt = 0;
      checked_cnt  = 0;
      expected_drive_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN_P:     kp      = cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_I:     ki      = cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_D:     kd      = cfg_data_i[GAIN_W-1:0];
          CFG_OUT_LIMIT:  out_lim = cfg_data_i[LIMIT_W-1:0];
          CFG_INT_LIMIT:  int_lim = cfg_data_i[LIMIT_W-1:0];
          CFG_BEGIN_BAND: band_hi = cfg_data_i[LIMIT_W-1:0];
          CFG_FULL_BAND:  band_lo = cfg_data_i[LIMIT_W-1:0];
          CFG_SEP_EN:     sep_en  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_loop(in_mon.setpoint, in_mon.measured, in_mon.ff_threshold,
                     in_mon.ff_step, want);
        expected_drive_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.drive       = out_mon.drive;
        got.error_value = out_mon.error_value;
        if (expected_drive_q.size() == 0) begin
          $display("%0t unexpected result word: drive %0d, error %0d", $time,
                   got.drive, got.error_value);
          mismatch_cnt++;
        end else begin
          want = expected_drive_q.pop_front();
          checked_cnt++;
          if (got.drive !== want.drive) begin
            $display("%0t drive mismatch: expected %0d, got %0d", $time,
                     want.drive, got.drive);
            mismatch_cnt++;
          end
          if (got.error_value !== want.error_value) begin
            $display("%0t error_value mismatch: expected %0d, got %0d", $time,
                     want.error_value, got.error_value);
            mismatch_cnt++;
          end
        end
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o      <= expected_drive_q.size();
    checked_o      <= checked_cnt;
  end

endmodule

>>> dv/position_pid_integral_separation_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the positional PID with integral separation: clock, reset,
// register programming, input words and output stalls, and the final verdict.
// Depends on ppis_pkg, ppis_in_if, ppis_out_if, ppis_drive_checker and the block itself.
module position_pid_integral_separation_tb;
  import ppis_pkg::*;

  // A few hundred words with gaps and stalls on each side, plus the long output hold-off,
  // finish well inside this limit, so it leaves a wide margin.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] ONE   = 32'sh00010000;
  localparam logic [GAIN_W-1:0]        G_ONE = 24'h010000;
  localparam logic [GAIN_W-1:0]        G_MAX = 24'hFFFFFF;
  localparam logic [LIMIT_W-1:0]       L_MAX = 31'h7FFFFFFF;

  // One full register setting of the loop.
  typedef struct {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] out_lim;
    logic [LIMIT_W-1:0] int_lim;
    logic [LIMIT_W-1:0] band_hi;
    logic [LIMIT_W-1:0] band_lo;
    logic               sep;
  } loop_setting_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ppis_in_if  word_in();
  ppis_out_if word_out();

  int mismatches;
  int pending;
  int checked;
  int words_sent;
  int settings_used;
  // When quiet is set neither side inserts idle cycles; hold_request asks the receiver for
  // one long hold-off so that the block fills up and pushes back on its input.
  bit quiet;
  bit hold_request;

  position_pid_integral_separation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (word_in),
    .out_o      (word_out)
  );

  ppis_drive_checker checker_u (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_mon         (word_in),
    .out_mon        (word_out),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Writes one register and leaves the write enable high; the caller lowers it once the
  // whole batch is done, so the enable never gets two assignments in one step.
  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Programmes all eight registers. The unused upper data bits of the narrow registers
  // carry random junk, which the block must ignore.
  task automatic apply_setting(input loop_setting_t s);
    put_reg(CFG_GAIN_P,     {7'($urandom), s.kp});
    put_reg(CFG_GAIN_I,     {7'($urandom), s.ki});
    put_reg(CFG_GAIN_D,     {7'($urandom), s.kd});
    put_reg(CFG_OUT_LIMIT,  s.out_lim);
    put_reg(CFG_INT_LIMIT,  s.int_lim);
    put_reg(CFG_BEGIN_BAND, s.band_hi);
    put_reg(CFG_FULL_BAND,  s.band_lo);
    put_reg(CFG_SEP_EN,     {30'($urandom), s.sep});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Offers one input word, possibly after a short idle burst, and returns at the edge
  // where it is accepted. Valid stays high so that back-to-back words need no re-raise.
  task automatic push_word(input logic signed [DATA_W-1:0] sp, ms, thr, stp);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      word_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    word_in.valid        <= 1'b1;
    word_in.setpoint     <= sp;
    word_in.measured     <= ms;
    word_in.ff_threshold <= thr;
    word_in.ff_step      <= stp;
    do @(posedge clk_i); while (!word_in.ready);
    words_sent++;
  endtask

  // Ends a phase: stops offering words, waits for every outstanding result word and then
  // gives the block time to return to idle before the registers are touched again.
  task automatic settle();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return G_MAX;
      2, 3:    return GAIN_W'($urandom_range(0, 32'h40000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return L_MAX;
      2:       return LIMIT_W'($urandom_range(0, 32'h0400_0000));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  // Random setting with a fair share of extremes. The bands are mostly kept modest so that
  // the errors of the random words land in all three regions, and now and then the full
  // band is made equal to or wider than the begin band.
  function automatic loop_setting_t random_setting();
    loop_setting_t s;
    s.kp      = random_gain();
    s.ki      = random_gain();
    s.kd      = random_gain();
    s.out_lim = random_limit();
    s.int_lim = random_limit();
    case ($urandom_range(0, 5))
      0:       s.band_hi = '0;
      1:       s.band_hi = L_MAX;
      default: s.band_hi = LIMIT_W'($urandom_range(0, 32'h0040_0000));
    endcase
    case ($urandom_range(0, 4))
      0:       s.band_lo = s.band_hi;
      1:       s.band_lo = (s.band_hi == L_MAX) ? L_MAX
                           : s.band_hi + LIMIT_W'($urandom_range(1, 32'h0002_0000));
      default: s.band_lo = LIMIT_W'($urandom_range(0, 32'(s.band_hi)));
    endcase
    s.sep = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  // Random input word. Most words aim the error at the bands of the current setting and the
  // threshold at the same scale; the rest are raw noise or corner values.
  task automatic push_random(input loop_setting_t s);
    longint                   span, err;
    logic signed [DATA_W-1:0] sp, ms, thr, stp;
    span = longint'(s.band_hi) + (longint'(s.band_hi) >>> 2) + 65536;
    if (span > 64'sd1073741824) span = 64'sd1073741824;
    sp = $urandom;
    if ($urandom_range(0, 1) == 0) sp = sp >>> $urandom_range(4, 16);
    err = longint'($urandom_range(0, 32'(2 * span))) - span;
    ms  = sp - DATA_W'(err);
    case ($urandom_range(0, 4))
      0:       thr = $urandom;
      1:       thr = corner_value();
      default: thr = DATA_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endcase
    stp = $urandom;
    if ($urandom_range(0, 1) == 0) stp = stp >>> 8;
    case ($urandom_range(0, 9))
      0: begin
        sp = $urandom;
        ms = $urandom;
      end
      1: begin
        sp  = corner_value();
        ms  = corner_value();
        stp = corner_value();
      end
      default: ;
    endcase
    push_word(sp, ms, thr, stp);
  endtask

  // Receiver. It idles in random bursts unless quiet is set, and once in the run holds
  // off for a long stretch, counted here, while the sender keeps offering.
  initial begin : receiver
    int gap_left;
    int hold_left;
    gap_left       = 0;
    hold_left      = 0;
    word_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        word_out.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        word_out.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap_left       = $urandom_range(0, 4);
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= 1'b1;
      end
    end
  end

  // A run that stops making progress ends here with the failure verdict.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d result words outstanding", cycles, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    loop_setting_t s;
    words_sent           = 0;
    settings_used        = 0;
    quiet                = 1'b0;
    hold_request         = 1'b0;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_GAIN_P;
    cfg_data_i           <= '0;
    word_in.valid        <= 1'b0;
    word_in.setpoint     <= '0;
    word_in.measured     <= '0;
    word_in.ff_threshold <= '0;
    word_in.ff_step      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: all gains are zero, so only the feed-forward step moves the drive.
    // The first word also saturates the error and the drive upwards.
    push_word(Q_MAX, Q_MIN, '0, Q_MAX);
    push_word(-ONE, ONE, Q_MIN, Q_MIN);
    settle();

    // Unity gains with separation on: begin band 10.0, full band 2.0. The words walk the
    // error through zero, both saturation directions, below the full band, the middle band,
    // exactly on each band edge and beyond the begin band on either side. The thresholds
    // cover the negative case, the largest value and an error exactly at the threshold.
    apply_setting('{G_ONE, G_ONE, G_ONE, L_MAX, L_MAX, 31'(10 * 65536), 31'(2 * 65536),
                    1'b1});
    push_word('0, '0, '0, '0);
    push_word(Q_MAX, Q_MIN, '0, Q_MAX);
    push_word(Q_MIN, Q_MAX, '0, Q_MAX);
    push_word(ONE, '0, Q_MIN, 1);
    push_word(5 * ONE, '0, -1, ONE);
    push_word(10 * ONE, '0, Q_MAX, Q_MIN);
    push_word(2 * ONE, '0, ONE, Q_MAX);
    push_word('0, 11 * ONE, '0, ONE);
    push_word(-3 * ONE, '0, 3 * ONE, Q_MIN);
    push_word(7 * ONE + 1234, -ONE, ONE, 32'sh12345678);
    settle();

    // Largest gains with both bands at 4.0: a zero divisor in the middle band means a
    // weight of one.
    apply_setting('{G_MAX, G_MAX, G_MAX, L_MAX, L_MAX, 31'(4 * 65536), 31'(4 * 65536),
                    1'b1});
    push_word(4 * ONE, '0, Q_MAX, '0);
    push_word('0, 4 * ONE, Q_MAX, '0);
    push_word(-ONE, '0, Q_MAX, '0);
    settle();

    // Separation off and full-scale errors: the accumulated error saturates at the top,
    // then is driven back down towards the bottom.
    apply_setting('{G_ONE, G_MAX, '0, L_MAX, L_MAX, '0, '0, 1'b0});
    push_word(Q_MAX, Q_MIN, Q_MAX, '0);
    push_word(Q_MAX, Q_MIN, Q_MAX, '0);
    push_word(Q_MAX, Q_MIN, Q_MAX, '0);
    push_word(Q_MIN, Q_MAX, Q_MAX, '0);
    push_word(Q_MIN, Q_MAX, Q_MAX, '0);
    settle();

    // Inverted bands (begin 2.0 below full 8.0) with a tight integral and output limit:
    // the begin test wins, so errors between the bands are not integrated.
    apply_setting('{G_ONE, G_ONE, '0, 31'(3 * 65536), 31'(65536), 31'(2 * 65536),
                    31'(8 * 65536), 1'b1});
    push_word(ONE, '0, '0, ONE);
    push_word(5 * ONE, '0, '0, ONE);
    push_word(-ONE - ONE / 2, '0, '0, ONE);
    push_word(2 * ONE, '0, '0, ONE);
    settle();

    // Random part: seven settings of a hundred words each. The second one includes the
    // long output hold-off, and the last runs with no idling on either side.
    for (int phase = 0; phase < 7; phase++) begin
      s = random_setting();
      if (phase == 6) quiet = 1'b1;
      apply_setting(s);
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 10) hold_request = 1'b1;
        push_random(s);
      end
      settle();
    end

    $display("Summary: %0d input words under %0d register settings, %0d result words checked.",
             words_sent, settings_used, checked);
    $display("Covered: saturating errors, all band regions, collapsed and inverted bands, %s",
             "feed-forward both ways and a long output stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
